@@ rtl/core/binned_decision_tree_lookup_top_macros.svh @@
// Assertion macros for the binned decision tree lookup block.
// Used by the top level; depends on nothing.
`ifndef BINNED_DECISION_TREE_LOOKUP_TOP_MACROS_SVH
`define BINNED_DECISION_TREE_LOOKUP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BDT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BDT_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDT_ASSERT(label, clk, rst_n, prop, msg)
`define BDT_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ rtl/core/bdt_pkg.sv @@
// Package for the binned decision tree lookup: commands, status codes, stage types.
// No dependencies.
`timescale 1ns / 1ps
package bdt_pkg;
  localparam logic [1:0] CMD_CLASSIFY = 2'd0;
  localparam logic [1:0] CMD_LOAD_SPLIT = 2'd1;
  localparam logic [1:0] CMD_LOAD_VOTE = 2'd2;
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;
  localparam logic [1:0] REG_VAR_COUNT = 2'd0;
  localparam logic [1:0] REG_SPLIT_COUNTS = 2'd1;
  localparam logic [1:0] REG_TREE_COUNT = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  typedef struct packed {
    logic        pass;
    logic [15:0] votes;
    logic [1:0]  status;
  } result_t;
endpackage

@@ rtl/core/bdt_if.sv @@
// Valid/ready channel interfaces: input word, result word, config write.
// No dependencies.
`timescale 1ns / 1ps
interface bdt_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [15:0]       table_address;
  logic signed [31:0] load_word;
  logic [7:0]        missing_mask;
  logic signed [31:0] value_0, value_1, value_2, value_3;
  logic signed [31:0] value_4, value_5, value_6, value_7;
  modport source (output valid, command, table_address, load_word, missing_mask,
    value_0, value_1, value_2, value_3, value_4, value_5, value_6, value_7, input ready);
  modport sink (input valid, command, table_address, load_word, missing_mask,
    value_0, value_1, value_2, value_3, value_4, value_5, value_6, value_7, output ready);
endinterface

interface bdt_out_if;
  logic        valid;
  logic        ready;
  logic        pass;
  logic [15:0] votes;
  logic [1:0]  status;
  modport source (output valid, pass, votes, status, input ready);
  modport sink (input valid, pass, votes, status, output ready);
endinterface

interface bdt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [39:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/bdt_lane.sv @@
// One binning lane: holds the split thresholds of one variable and finds its bin.
// No dependencies.
`timescale 1ns / 1ps
module bdt_lane #(
  parameter int MAX_SPLITS = 16,
  localparam int SW = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               wr_i,
  input  logic [SW-1:0]      wr_split_i,
  input  logic signed [31:0] wr_data_i,
  input  logic signed [31:0] value_i,
  input  logic [4:0]         count_i,
  output logic [4:0]         bin_o
);
  logic signed [31:0] split_q [MAX_SPLITS];
  logic [MAX_SPLITS-1:0] below;
  logic [4:0] bin_d;

  always_ff @(posedge clk_i) begin
    if (wr_i) split_q[wr_split_i] <= wr_data_i;
  end

  always_comb begin
    for (int s = 0; s < MAX_SPLITS; s++) below[s] = value_i < split_q[s];
  end

  // bin = count-1 (0 if count is 0) unless some split s in 1..count-1 is above the value; split 0 above gives 0
  always_comb begin
    bin_d = (count_i == 5'd0) ? 5'd0 : count_i - 5'd1;
    for (int s = MAX_SPLITS - 1; s >= 1; s--) begin
      if (5'(s) < count_i && below[s]) bin_d = 5'(s - 1);
    end
    if (below[0]) bin_d = 5'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) bin_o <= bin_d;
  end
endmodule

@@ rtl/core/bdt_merge.sv @@
// Merge stage: folds lane bins into the mixed-radix table index.
// Radix weights settle one multiply per cycle after a config change; depends on nothing else.
`timescale 1ns / 1ps
module bdt_merge #(
  parameter int MAX_VARIABLES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        cfg_wr_i,
  input  logic [4:0]  bin_i [MAX_VARIABLES],
  input  logic [4:0]  count_i [MAX_VARIABLES],
  input  logic [3:0]  nv_i,
  output logic        busy_o,
  output logic [40:0] index_o,
  output logic [40:0] mult_o
);
  localparam int SETTLE = MAX_VARIABLES + 1;
  localparam int CW = $clog2(SETTLE + 1);

  logic [40:0] weight_q [MAX_VARIABLES];
  logic [40:0] total_q;
  logic [CW-1:0] settle_q;
  logic [40:0] idx;

  // weight of variable k: product of the radices of the used variables after it
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_VARIABLES - 1; k++) begin
      if (4'(k + 1) < nv_i) weight_q[k] <= 41'(weight_q[k + 1] * 41'(count_i[k + 1]));
      else weight_q[k] <= 41'd1;
    end
    weight_q[MAX_VARIABLES - 1] <= 41'd1;
    total_q <= (nv_i == 4'd0) ? 41'd1 : 41'(weight_q[0] * 41'(count_i[0]));
  end

  // hold off new words until the weight chain has settled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= CW'(SETTLE);
    end else if (cfg_wr_i) begin
      settle_q <= CW'(SETTLE);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - CW'(1);
    end
  end
  assign busy_o = settle_q != '0;

  always_comb begin
    idx = '0;
    for (int k = 0; k < MAX_VARIABLES; k++) begin
      if (4'(k) < nv_i) idx = idx + 41'(41'(bin_i[k]) * weight_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      index_o <= idx;
      mult_o <= total_q;
    end
  end
endmodule

@@ rtl/core/binned_decision_tree_lookup_top.sv @@
// Top level of the binned decision tree lookup: lanes, merge, vote memory, output.
// Depends on bdt_pkg, bdt_if, bdt_lane, bdt_merge and the macro header.
`timescale 1ns / 1ps
`include "binned_decision_tree_lookup_top_macros.svh"
// One word per cycle enters and leaves while the line neither stalls nor settles;
// a result word passes four registers after its input word is taken (lane bin,
// loaded on the accepting edge, index merge, vote memory read, output). Eight lanes
// bin their variable at once against their own thresholds; the merge stage builds
// the table index from radix weights that settle one multiply per cycle, so after
// reset and after every config write ready stays low until the weights have settled.
// The vote memory has one write and one read port. The pipeline advances whenever
// its output stage is empty or being taken, so a full output register stalls the
// whole line and ready drops with it. Split loads write their lane as they enter;
// vote loads travel down the line and write the memory at the read stage, so every
// classify sees exactly the loads taken before it.
module binned_decision_tree_lookup_top #(
  parameter int MAX_VARIABLES = 8,
  parameter int MAX_SPLITS = 16,
  parameter int VOTE_DEPTH = 65536
) (
  input  logic clk_i,
  input  logic rst_ni,
  bdt_in_if.sink    in_if,
  bdt_out_if.source out_if,
  bdt_cfg_if.sink   cfg_if
);
  localparam int SW = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;
  localparam int AW = $clog2(VOTE_DEPTH);

  logic [3:0] var_count_q;
  logic [39:0] split_counts_q;
  logic [15:0] tree_count_q;
  logic signed [31:0] threshold_q;
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_count_q <= 4'd1;
      split_counts_q <= 40'd35468117025;
      tree_count_q <= 16'd1;
      threshold_q <= -32'sd65536;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        bdt_pkg::REG_VAR_COUNT:    var_count_q <= cfg_if.data[3:0];
        bdt_pkg::REG_SPLIT_COUNTS: split_counts_q <= cfg_if.data;
        bdt_pkg::REG_TREE_COUNT:   tree_count_q <= cfg_if.data[15:0];
        bdt_pkg::REG_THRESHOLD:    threshold_q <= cfg_if.data[31:0];
        default: ;
      endcase
    end
  end

  // saturated counts
  logic [4:0] count [MAX_VARIABLES];
  logic [3:0] nv;
  always_comb begin
    for (int v = 0; v < MAX_VARIABLES; v++) begin
      count[v] = split_counts_q[5*v +: 5];
      if (count[v] > 5'(MAX_SPLITS)) count[v] = 5'(MAX_SPLITS);
    end
    nv = (var_count_q > 4'(MAX_VARIABLES)) ? 4'(MAX_VARIABLES) : var_count_q;
  end

  // pipeline control: s1 lanes, s2 merge, s3 memory read, s4 output
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv;
  logic settle;
  assign adv = !v4_q || out_if.ready;
  assign in_if.ready = adv && !settle;
  logic acc;
  assign acc = in_if.valid && adv && !settle;

  logic is_cls, miss;
  logic [7:0] use_mask;
  always_comb begin
    for (int v = 0; v < 8; v++) use_mask[v] = 4'(v) < nv;
  end
  assign is_cls = in_if.command == bdt_pkg::CMD_CLASSIFY;
  assign miss = |(in_if.missing_mask & use_mask);

  // vote loads ride along to the read stage
  logic vw_d;
  logic vw1_q, vw2_q;
  logic [AW-1:0] va1_q, va2_q;
  logic [15:0] vd1_q, vd2_q;
  assign vw_d = acc && in_if.command == bdt_pkg::CMD_LOAD_VOTE
                && 17'(in_if.table_address) < 17'(VOTE_DEPTH);

  logic [1:0] cls1_q, cls2_q, cls3_q; // {is_classify, missing}
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      vw1_q <= 1'b0; vw2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= acc; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      vw1_q <= vw_d; vw2_q <= vw1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls1_q <= {is_cls, miss}; cls2_q <= cls1_q; cls3_q <= cls2_q;
      va1_q <= in_if.table_address[AW-1:0]; va2_q <= va1_q;
      vd1_q <= in_if.load_word[15:0]; vd2_q <= vd1_q;
    end
  end

  logic signed [31:0] values [8];
  assign values = '{in_if.value_0, in_if.value_1, in_if.value_2, in_if.value_3,
                    in_if.value_4, in_if.value_5, in_if.value_6, in_if.value_7};
  logic [11:0] ld_var;
  assign ld_var = in_if.table_address[15:4];
  logic [4:0] bin [MAX_VARIABLES];

  for (genvar g = 0; g < MAX_VARIABLES; g++) begin : g_lane
    logic wr;
    assign wr = acc && in_if.command == bdt_pkg::CMD_LOAD_SPLIT && ld_var == 12'(g)
                && {1'b0, in_if.table_address[3:0]} < 5'(MAX_SPLITS);
    bdt_lane #(.MAX_SPLITS(MAX_SPLITS)) u_lane (
      .clk_i, .en_i(adv), .wr_i(wr), .wr_split_i(in_if.table_address[SW-1:0]),
      .wr_data_i(in_if.load_word), .value_i(values[g]), .count_i(count[g]),
      .bin_o(bin[g])
    );
  end

  logic [40:0] index2, mult2;
  bdt_merge #(.MAX_VARIABLES(MAX_VARIABLES)) u_merge (
    .clk_i, .rst_ni, .en_i(adv), .cfg_wr_i(cfg_if.valid && cfg_if.ready),
    .bin_i(bin), .count_i(count), .nv_i(nv), .busy_o(settle),
    .index_o(index2), .mult_o(mult2)
  );

  // vote memory: write and read both at the s2 -> s3 step
  logic [15:0] vote_mem [VOTE_DEPTH];
  logic [15:0] rd_q;
  logic out3_q;
  always_ff @(posedge clk_i) begin
    if (adv && vw2_q) vote_mem[va2_q] <= vd2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q <= vote_mem[index2[AW-1:0]];
      out3_q <= index2 >= mult2 || index2 >= 41'(VOTE_DEPTH);
    end
  end

  // compare stage into output register
  logic signed [48:0] lhs, rhs;
  bdt_pkg::result_t res_d, res_q;
  assign lhs = {9'd0, rd_q, 16'd0};
  assign rhs = 49'(threshold_q) * $signed({1'b0, tree_count_q});
  always_comb begin
    res_d = '{pass: 1'b0, votes: 16'd0, status: bdt_pkg::ST_LOAD};
    if (cls3_q[1]) begin
      if (cls3_q[0]) res_d.status = bdt_pkg::ST_MISSING;
      else if (out3_q) res_d.status = bdt_pkg::ST_OUTSIDE;
      else res_d = '{pass: lhs > rhs, votes: rd_q, status: bdt_pkg::ST_OK};
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end
  assign out_if.valid = v4_q;
  assign out_if.pass = res_q.pass;
  assign out_if.votes = res_q.votes;
  assign out_if.status = res_q.status;

  `BDT_ASSERT(a_stall_hold, clk_i, rst_ni, out_if.valid && !out_if.ready |=> $stable(res_q), "output word changed while stalled")
  `BDT_ASSERT(a_err_zero, clk_i, rst_ni, out_if.valid && out_if.status != bdt_pkg::ST_OK |-> !out_if.pass && out_if.votes == 16'd0, "error word carries votes")
  `BDT_ASSERT_RST(a_ready, clk_i, v4_q || !rst_ni || settle || in_if.ready, "ready low with empty output")
endmodule

@@ sim/bdt_scoreboard_pkg.sv @@
// Vote lookup predictor and expected-word store for the decision tree testbench.
// Depends on bdt_pkg.
`timescale 1ns / 1ps
package bdt_scoreboard_pkg;

  typedef struct {
    logic [1:0]         command;
    logic [15:0]        table_address;
    logic signed [31:0] load_word;
    logic [7:0]         missing_mask;
    logic signed [31:0] value [8];
  } word_t;

  class vote_scoreboard;
    logic [3:0]         var_count;
    logic [39:0]        split_counts;
    logic [15:0]        tree_count;
    logic signed [31:0] threshold;
    logic signed [31:0] splits [8][16];
    logic [15:0]        votes_mem [int];
    bdt_pkg::result_t   pending [$];
    int                 fail_count;

    function new();
      var_count = 1;
      split_counts = 40'd35468117025;
      tree_count = 1;
      threshold = -32'sd65536;
      fail_count = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [39:0] data);
      case (idx)
        bdt_pkg::REG_VAR_COUNT:    var_count = data[3:0];
        bdt_pkg::REG_SPLIT_COUNTS: split_counts = data;
        bdt_pkg::REG_TREE_COUNT:   tree_count = data[15:0];
        default:                   threshold = data[31:0];
      endcase
    endfunction

    function int radix(int v);
      int n;
      n = split_counts[5*v +: 5];
      return (n > 16) ? 16 : n;
    endfunction

    function void note_word(word_t w);
      bdt_pkg::result_t r;
      int nv, n, b;
      longint idx, mult;
      longint lhs, rhs;
      r = '{pass: 1'b0, votes: 16'd0, status: bdt_pkg::ST_LOAD};
      if (w.command == bdt_pkg::CMD_LOAD_SPLIT) begin
        if (w.table_address[15:4] < 8) splits[w.table_address[6:4]][w.table_address[3:0]] = w.load_word;
      end else if (w.command == bdt_pkg::CMD_LOAD_VOTE) begin
        votes_mem[w.table_address] = w.load_word[15:0];
      end else if (w.command == bdt_pkg::CMD_CLASSIFY) begin
        nv = (var_count > 8) ? 8 : var_count;
        idx = 0;
        mult = 1;
        for (int v = 0; v < nv; v++)
          if (w.missing_mask[v]) r.status = bdt_pkg::ST_MISSING;
        if (r.status != bdt_pkg::ST_MISSING) begin
          for (int v = nv - 1; v >= 0; v--) begin
            n = radix(v);
            b = 0;
            if (n != 0 && w.value[v] >= splits[v][0]) begin
              b = n - 1;
              for (int s = n - 1; s >= 1; s--)
                if (w.value[v] < splits[v][s]) b = s - 1;
            end
            idx += b * mult;
            mult *= n;
          end
          if (idx >= mult || idx >= 65536) r.status = bdt_pkg::ST_OUTSIDE;
          else begin
            r.status = bdt_pkg::ST_OK;
            r.votes = votes_mem.exists(int'(idx)) ? votes_mem[int'(idx)] : 16'd0;
            lhs = longint'(r.votes) * 65536;
            rhs = longint'(threshold) * longint'(tree_count);
            r.pass = lhs > rhs;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_word(bdt_pkg::result_t got);
      bdt_pkg::result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word pass=%0d votes=%0d status=%0d",
                 $time, got.pass, got.votes, got.status);
        fail_count++;
        return;
      end
      exp = pending.pop_front();
      if (got.pass !== exp.pass) begin
        $display("%0t: pass expected %0d actual %0d", $time, exp.pass, got.pass);
        fail_count++;
      end
      if (got.votes !== exp.votes) begin
        $display("%0t: votes expected %0d actual %0d", $time, exp.votes, got.votes);
        fail_count++;
      end
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        fail_count++;
      end
    endfunction
  endclass
endpackage

@@ sim/tb_binned_decision_tree_lookup_top.sv @@
// Testbench for binned_decision_tree_lookup_top: loads splits and votes, then
// classifies directed and random words under several idling phases.
// Depends on bdt_pkg, bdt_if, bdt_scoreboard_pkg and the RTL.
`timescale 1ns / 1ps
module tb_binned_decision_tree_lookup_top;

  logic clk_i;
  logic rst_ni;

  bdt_in_if  in_if ();
  bdt_out_if out_if ();
  bdt_cfg_if cfg_if ();

  binned_decision_tree_lookup_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  bdt_scoreboard_pkg::vote_scoreboard sb;
  int idle_pct;   // sender gap odds, per hundred
  int stall_pct;  // receiver stall odds, per hundred
  bit vote_written [int];

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop; far above the slowest legal run.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stalls, results checked at the accepting edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready)
        sb.check_word('{pass: out_if.pass, votes: out_if.votes, status: out_if.status});
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Push one word; an idle gap drops valid first, valid stays high until the handshake.
  task automatic send_word(bdt_scoreboard_pkg::word_t w);
    if ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.command       <= w.command;
    in_if.table_address <= w.table_address;
    in_if.load_word     <= w.load_word;
    in_if.missing_mask  <= w.missing_mask;
    in_if.value_0 <= w.value[0]; in_if.value_1 <= w.value[1];
    in_if.value_2 <= w.value[2]; in_if.value_3 <= w.value[3];
    in_if.value_4 <= w.value[4]; in_if.value_5 <= w.value[5];
    in_if.value_6 <= w.value[6]; in_if.value_7 <= w.value[7];
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_word(w);
    if (w.command == bdt_pkg::CMD_LOAD_VOTE) vote_written[w.table_address] = 1'b1;
  endtask

  task automatic end_burst();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for all results, then the pipeline depth, before a register write.
  task automatic drain();
    int guard;
    end_burst();
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [39:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic bdt_scoreboard_pkg::word_t blank_word();
    bdt_scoreboard_pkg::word_t w;
    w.command = bdt_pkg::CMD_CLASSIFY;
    w.table_address = '0;
    w.load_word = '0;
    w.missing_mask = '0;
    for (int v = 0; v < 8; v++) w.value[v] = '0;
    return w;
  endfunction

  task automatic load_split(int v, int s, logic signed [31:0] thr);
    bdt_scoreboard_pkg::word_t w;
    w = blank_word();
    w.command = bdt_pkg::CMD_LOAD_SPLIT;
    w.table_address = 16'(v * 16 + s);
    w.load_word = thr;
    send_word(w);
  endtask

  task automatic load_vote(int a, logic signed [31:0] val);
    bdt_scoreboard_pkg::word_t w;
    w = blank_word();
    w.command = bdt_pkg::CMD_LOAD_VOTE;
    w.table_address = 16'(a);
    w.load_word = val;
    send_word(w);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(2000)) - 32'sd1000;
      default: return $urandom;
    endcase
  endfunction

  // Random classify; missing bits, vote loads, no-ops and out-of-range split loads mixed in as noise.
  task automatic random_word(int nv, int table_size);
    bdt_scoreboard_pkg::word_t w;
    int r;
    w = blank_word();
    r = $urandom_range(99);
    if (r < 8) begin
      w.command = bdt_pkg::CMD_LOAD_VOTE;
      w.table_address = 16'($urandom_range(table_size - 1));
      w.load_word = $urandom;
    end else if (r < 11) begin
      w.command = bdt_pkg::CMD_NOP;
      w.table_address = 16'($urandom);
      w.load_word = $urandom;
      w.missing_mask = 8'($urandom);
    end else if (r < 13) begin
      // out-of-range split load: ignored by the block
      w.command = bdt_pkg::CMD_LOAD_SPLIT;
      w.table_address = 16'(128 + $urandom_range(65407));
      w.load_word = $urandom;
    end else begin
      w.missing_mask = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom) & ~8'((1 << nv) - 1);
      for (int v = 0; v < 8; v++) w.value[v] = rand_value();
    end
    send_word(w);
  endtask

  // A setting: counts, splits loaded sorted, vote table loaded when it is small.
  task automatic setup(int nv, int radix [8], logic [15:0] trees, logic signed [31:0] thr);
    logic [39:0] packed_counts;
    int tsize, nu;
    logic signed [31:0] base;
    drain();
    nu = (nv > 8) ? 8 : nv;
    packed_counts = '0;
    tsize = 1;
    for (int v = 0; v < 8; v++) packed_counts[5*v +: 5] = 5'(radix[v]);
    for (int v = 0; v < nu; v++) tsize *= (radix[v] > 16) ? 16 : radix[v];
    write_reg(bdt_pkg::REG_VAR_COUNT, 40'(nv));
    write_reg(bdt_pkg::REG_SPLIT_COUNTS, packed_counts);
    write_reg(bdt_pkg::REG_TREE_COUNT, 40'(trees));
    write_reg(bdt_pkg::REG_THRESHOLD, 40'(unsigned'(thr)));
    for (int v = 0; v < nu; v++) begin
      base = 32'($urandom_range(4000)) - 32'sd2000;
      for (int s = 0; s < radix[v] && s < 16; s++) begin
        load_split(v, s, base);
        base += 32'($urandom_range(300));
      end
    end
    if (tsize <= 2048) begin
      for (int a = 0; a < tsize; a++)
        if (tsize <= 64 || !vote_written.exists(a)) load_vote(a, $urandom);
    end
  endtask

  int radix [8];
  int nv, tsize, sent;
  bdt_scoreboard_pkg::word_t w;

  initial begin
    sb = new();
    idle_pct = 0;
    stall_pct = 0;
    in_if.valid = 1'b0;
    in_if.command = bdt_pkg::CMD_CLASSIFY;
    in_if.table_address = '0;
    in_if.load_word = '0;
    in_if.missing_mask = '0;
    {in_if.value_0, in_if.value_1, in_if.value_2, in_if.value_3} = '0;
    {in_if.value_4, in_if.value_5, in_if.value_6, in_if.value_7} = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = bdt_pkg::REG_VAR_COUNT;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, one variable of one split.
    load_split(0, 0, 32'sd0);
    load_vote(0, 32'sd7);
    w = blank_word();
    w.value[0] = 32'sh80000000; send_word(w);          // below split 0
    w.value[0] = 32'sh7fffffff; send_word(w);          // top bin
    w.missing_mask = 8'h01; send_word(w);              // variable missing
    w.missing_mask = 8'hfe; send_word(w);              // unused bits ignored
    w = blank_word(); w.command = bdt_pkg::CMD_NOP; send_word(w);  // no-op command
    load_split(8, 0, 32'sd5);                          // variable 8: ignored
    load_vote(1, 32'shffff_0005);                      // high bits dropped

    // Three variables, radix 3,2,4; threshold and tree extremes.
    radix = '{3, 2, 4, 1, 1, 1, 1, 1};
    setup(3, radix, 16'hffff, 32'sh7fffffff);
    for (int i = 0; i < 6; i++) random_word(3, 24);
    radix = '{3, 2, 4, 1, 1, 1, 1, 1};
    setup(3, radix, 16'd0, 32'sh80000000);             // no trees: votes > 0
    w = blank_word(); send_word(w);
    for (int i = 0; i < 6; i++) random_word(3, 24);
    // Split count zero: empty table.
    radix = '{0, 1, 1, 1, 1, 1, 1, 1};
    setup(1, radix, 16'd1, 32'sd0);
    w = blank_word(); send_word(w);
    // Variable count zero, and above eight (saturates).
    radix = '{1, 1, 1, 1, 1, 1, 1, 1};
    setup(0, radix, 16'd3, 32'sd0);
    w = blank_word(); w.missing_mask = 8'hff; send_word(w);
    radix = '{2, 1, 1, 1, 1, 1, 1, 2};
    setup(15, radix, 16'd10, 32'sd32768);
    w = blank_word(); w.missing_mask = 8'h80; send_word(w);
    // Split count above sixteen saturates; a top bin on variable 0 lands past the table.
    radix = '{31, 16, 16, 16, 2, 1, 1, 1};
    setup(5, radix, 16'd100, 32'sd1000);
    for (int i = 0; i < 4; i++) begin
      w = blank_word();
      for (int v = 1; v < 8; v++) w.value[v] = rand_value();
      w.value[0] = 32'sh7fffffff;
      send_word(w);
    end

    // Random phases under different idling.
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      nv = $urandom_range(1, 8);
      tsize = 1;
      for (int v = 0; v < 8; v++) begin
        if (v < nv) begin
          radix[v] = $urandom_range(1, 6);
          if (tsize * radix[v] > 64) radix[v] = 1;
          tsize *= radix[v];
        end else begin
          radix[v] = $urandom_range(31);
        end
      end
      vote_written.delete();
      setup(nv, radix, 16'($urandom), $urandom);
      for (int i = 0; i < 120; i++) random_word(nv, tsize);
    end

    drain();
    if (sb.fail_count == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
